// ===== rtl/pos_vel_kalman_filter_unit_assert.svh =====
// Assertion macros shared by the filter RTL.
// Each expects clk and rst_n in scope.
`ifndef POS_VEL_KALMAN_FILTER_UNIT_ASSERT_SVH
`define POS_VEL_KALMAN_FILTER_UNIT_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define PVK_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pvk: same-cycle check failed");

// Consequent holds in the cycle after the antecedent.
`define PVK_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pvk: next-cycle check failed");

`endif

// ===== rtl/pvk_pkg.sv =====
package pvk_pkg;

    localparam int FRAC_BITS  = 24;
    localparam int ACCEL_FRAC = 16;

    // product magnitude clamp, 2^60, needs 61 bits
    localparam int TERM_W = 61;
    localparam int SH_W   = 6;
    localparam int DT2_W  = 64 - FRAC_BITS;
    localparam int DIV_CNT_W = $clog2(FRAC_BITS + 1);

    typedef logic [127:0] wide_t;

    localparam wide_t TERM_LIM = 128'd1 << 60;
    // floor(1e-7 * 2^(2F))
    localparam wide_t EPS_DET  = (128'd1 << (2 * FRAC_BITS - 4)) / 128'd625000;

    localparam logic signed [63:0] S56_MAX = 64'sh007F_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S56_MIN = 64'shFF80_0000_0000_0000;
    localparam logic [63:0]        U48_MAX = 64'h0000_FFFF_FFFF_FFFF;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_STD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_MEAS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VEL_MEAS  = 2'd2;

    localparam logic MODE_PREDICT = 1'b0;

    // status of a shared multi-cycle unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

    // shift right, clamp magnitude to 2^60
    function automatic logic [TERM_W-1:0] shr_clamp(wide_t x, logic [SH_W-1:0] sh);
        wide_t s;
        s = x >> sh;
        if (s > TERM_LIM)
            return TERM_LIM[TERM_W-1:0];
        return s[TERM_W-1:0];
    endfunction

    function automatic logic [55:0] sat56(logic signed [63:0] x);
        if (x > S56_MAX)
            return S56_MAX[55:0];
        else if (x < S56_MIN)
            return S56_MIN[55:0];
        return x[55:0];
    endfunction

    function automatic logic [47:0] sat48(logic [63:0] x);
        if (x > U48_MAX)
            return U48_MAX[47:0];
        return x[47:0];
    endfunction

    function automatic logic [63:0] abs64(logic signed [63:0] x);
        if (x < 0)
            return 64'(-x);
        return 64'(x);
    endfunction

endpackage

// ===== rtl/pos_vel_kalman_filter_unit.sv =====
// Channel   Handshake            Word
// in        in_valid / in_stall   mode, time_step, accel_sample, fix_position, fix_velocity
// out       out_valid / out_stall position_est, velocity_est, position_var, velocity_var
// cfg       cfg_valid / cfg_ready cfg_index, cfg_data (always ready)
//
// One word at a time; in_stall stays high from accept until the result is loaded.
// Each product is formed on the single 32x32 multiplier; each gain division runs on the
// bit-serial divider. Predict steps: DT2, Q, T1 to T4, UPD, OUT. Correction steps: DET, N0,
// DIV0, N1, DIV1, TP, TV, PV, VV, UPD, OUT.
// A result waits in its own output register, so the next word is taken while it stalls.
// Reset clears the estimates and variances and sets the three noise registers to 1.0.
`include "pos_vel_kalman_filter_unit_assert.svh"

module pos_vel_kalman_filter_unit
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_stall,
    input  logic                mode,
    input  logic [31:0]         time_step,
    input  logic signed [31:0]  accel_sample,
    input  logic signed [55:0]  fix_position,
    input  logic signed [55:0]  fix_velocity,

    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [55:0]  position_est,
    output logic signed [55:0]  velocity_est,
    output logic [47:0]         position_var,
    output logic [47:0]         velocity_var,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [pvk_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [47:0]         cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE, S_DT2, S_Q, S_T1, S_T2, S_T3, S_T4,
        S_DET, S_N0, S_DIV0, S_N1, S_DIV1, S_TP, S_TV, S_PV, S_VV,
        S_UPD, S_OUT
    } state_t;

    state_t state_reg;
    logic   busy_reg;

    // configuration
    logic [31:0] std_reg;
    logic [47:0] pmv_reg, vmv_reg;

    // latched input word
    logic [31:0]        dt_reg;
    logic signed [31:0] accel_reg;
    logic signed [55:0] zp_reg, zv_reg;

    // filter state
    logic signed [55:0] pos_reg, vel_reg;
    logic [47:0]        pvar_reg, vvar_reg;

    // working values
    logic [48:0]         s0_reg, s1_reg;
    logic [pvk_pkg::DT2_W-1:0] dt2_reg;
    pvk_pkg::wide_t      det_reg, num_reg;
    logic [pvk_pkg::FRAC_BITS-1:0] k0_reg, k1_reg;
    logic signed [63:0]  p_acc_reg, v_acc_reg;
    logic [63:0]         pv_acc_reg, vv_acc_reg;

    // output register
    logic               out_valid_reg;
    logic signed [55:0] pos_out_reg, vel_out_reg;
    logic [47:0]        pvar_out_reg, vvar_out_reg;

    // shared units
    logic                  mul_start, div_start;
    logic [63:0]           op_a, op_b;
    pvk_pkg::wide_t        mul_prod;
    pvk_pkg::unit_status_t mul_st, div_st;
    logic [pvk_pkg::FRAC_BITS-1:0] div_quo;

    logic                  is_mul_state, unit_done;
    logic [pvk_pkg::SH_W-1:0] sh_amt;
    logic                  term_neg;
    logic [pvk_pkg::TERM_W-1:0] term_mag;
    logic signed [63:0]    term_s;
    logic signed [56:0]    dp, dv;
    logic [pvk_pkg::FRAC_BITS:0] one_k0, one_k1;
    logic [pvk_pkg::DT2_W-1:0] sq_shr;
    logic                  in_acc, out_free;

    pvk_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (op_a),
        .op_b    (op_b),
        .product (mul_prod),
        .status  (mul_st)
    );

    pvk_div u_div
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (num_reg),
        .den    (det_reg),
        .quo    (div_quo),
        .status (div_st)
    );

    // operand select and product post-processing
    always_comb
    begin
        dp     = 57'(zp_reg) - 57'(pos_reg);
        dv     = 57'(zv_reg) - 57'(vel_reg);
        one_k0 = (pvk_pkg::FRAC_BITS+1)'(1) << pvk_pkg::FRAC_BITS;
        one_k1 = one_k0 - (pvk_pkg::FRAC_BITS+1)'(k1_reg);
        one_k0 = one_k0 - (pvk_pkg::FRAC_BITS+1)'(k0_reg);

        is_mul_state = state_reg inside {S_DT2, S_Q, S_T1, S_T2, S_T3, S_T4,
                                         S_DET, S_N0, S_N1, S_TP, S_TV, S_PV, S_VV};
        mul_start = is_mul_state && !busy_reg;
        div_start = (state_reg == S_DIV0 || state_reg == S_DIV1) && !busy_reg;
        unit_done = is_mul_state ? mul_st.done : div_st.done;

        sh_amt   = pvk_pkg::SH_W'(pvk_pkg::FRAC_BITS);
        term_neg = 1'b0;
        case (state_reg)
            S_DT2:
            begin
                op_a = 64'(dt_reg);
                op_b = 64'(dt_reg);
            end
            S_Q:
            begin
                op_a = 64'(std_reg);
                op_b = 64'(std_reg);
            end
            S_T1:
            begin
                op_a     = pvk_pkg::abs64(64'(vel_reg));
                op_b     = 64'(dt_reg);
                term_neg = vel_reg[55];
            end
            S_T2:
            begin
                op_a     = pvk_pkg::abs64(64'(accel_reg));
                op_b     = 64'(dt2_reg);
                sh_amt   = pvk_pkg::SH_W'(pvk_pkg::ACCEL_FRAC + 1);
                term_neg = accel_reg[31];
            end
            S_T3:
            begin
                op_a     = pvk_pkg::abs64(64'(accel_reg));
                op_b     = 64'(dt_reg);
                sh_amt   = pvk_pkg::SH_W'(pvk_pkg::ACCEL_FRAC);
                term_neg = accel_reg[31];
            end
            S_T4:
            begin
                op_a = 64'(dt2_reg);
                op_b = 64'(vvar_reg);
            end
            S_DET:
            begin
                op_a = 64'(s0_reg);
                op_b = 64'(s1_reg);
            end
            S_N0:
            begin
                op_a = 64'(pvar_reg);
                op_b = 64'(s1_reg);
            end
            S_N1:
            begin
                op_a = 64'(vvar_reg);
                op_b = 64'(s0_reg);
            end
            S_TP:
            begin
                op_a     = pvk_pkg::abs64(64'(dp));
                op_b     = 64'(k0_reg);
                term_neg = dp[56];
            end
            S_TV:
            begin
                op_a     = pvk_pkg::abs64(64'(dv));
                op_b     = 64'(k1_reg);
                term_neg = dv[56];
            end
            S_PV:
            begin
                op_a = 64'(one_k0);
                op_b = 64'(pvar_reg);
            end
            S_VV:
            begin
                op_a = 64'(one_k1);
                op_b = 64'(vvar_reg);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase

        term_mag = pvk_pkg::shr_clamp(mul_prod, sh_amt);
        term_s   = term_neg ? -$signed(64'(term_mag)) : $signed(64'(term_mag));
        sq_shr   = mul_prod[63:pvk_pkg::FRAC_BITS];
    end

    // handshakes
    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            std_reg <= 32'd1 << pvk_pkg::FRAC_BITS;
            pmv_reg <= 48'd1 << pvk_pkg::FRAC_BITS;
            vmv_reg <= 48'd1 << pvk_pkg::FRAC_BITS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pvk_pkg::CFG_ACCEL_STD: std_reg <= cfg_data[31:0];
                pvk_pkg::CFG_POS_MEAS:  pmv_reg <= cfg_data;
                pvk_pkg::CFG_VEL_MEAS:  vmv_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            busy_reg      <= 1'b0;
            dt_reg        <= '0;
            accel_reg     <= '0;
            zp_reg        <= '0;
            zv_reg        <= '0;
            pos_reg       <= '0;
            vel_reg       <= '0;
            pvar_reg      <= '0;
            vvar_reg      <= '0;
            s0_reg        <= '0;
            s1_reg        <= '0;
            dt2_reg       <= '0;
            det_reg       <= '0;
            num_reg       <= '0;
            k0_reg        <= '0;
            k1_reg        <= '0;
            p_acc_reg     <= '0;
            v_acc_reg     <= '0;
            pv_acc_reg    <= '0;
            vv_acc_reg    <= '0;
            out_valid_reg <= 1'b0;
            pos_out_reg   <= '0;
            vel_out_reg   <= '0;
            pvar_out_reg  <= '0;
            vvar_out_reg  <= '0;
        end
        else
        begin
            // a load in S_OUT takes the place of the clear
            if (out_valid_reg && !out_stall && state_reg != S_OUT)
                out_valid_reg <= 1'b0;

            if (mul_start || div_start)
                busy_reg <= 1'b1;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        dt_reg     <= time_step;
                        accel_reg  <= accel_sample;
                        zp_reg     <= fix_position;
                        zv_reg     <= fix_velocity;
                        s0_reg     <= 49'(pvar_reg) + 49'(pmv_reg);
                        s1_reg     <= 49'(vvar_reg) + 49'(vmv_reg);
                        p_acc_reg  <= 64'(pos_reg);
                        v_acc_reg  <= 64'(vel_reg);
                        pv_acc_reg <= 64'(pvar_reg);
                        vv_acc_reg <= 64'(vvar_reg);
                        state_reg  <= (mode == pvk_pkg::MODE_PREDICT) ? S_DT2 : S_DET;
                    end
                end
                S_UPD:
                begin
                    pos_reg   <= pvk_pkg::sat56(p_acc_reg);
                    vel_reg   <= pvk_pkg::sat56(v_acc_reg);
                    pvar_reg  <= pvk_pkg::sat48(pv_acc_reg);
                    vvar_reg  <= pvk_pkg::sat48(vv_acc_reg);
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        pos_out_reg   <= pos_reg;
                        vel_out_reg   <= vel_reg;
                        pvar_out_reg  <= pvar_reg;
                        vvar_out_reg  <= vvar_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    // arithmetic step: capture the unit result and move on
                    if (busy_reg && unit_done)
                    begin
                        busy_reg <= 1'b0;
                        case (state_reg)
                            S_DT2:
                            begin
                                dt2_reg   <= sq_shr;
                                state_reg <= S_Q;
                            end
                            S_Q:
                            begin
                                pv_acc_reg <= pv_acc_reg + 64'(sq_shr);
                                vv_acc_reg <= 64'(vvar_reg) + 64'(sq_shr);
                                state_reg  <= S_T1;
                            end
                            S_T1:
                            begin
                                p_acc_reg <= p_acc_reg + term_s;
                                state_reg <= S_T2;
                            end
                            S_T2:
                            begin
                                p_acc_reg <= p_acc_reg + term_s;
                                state_reg <= S_T3;
                            end
                            S_T3:
                            begin
                                v_acc_reg <= v_acc_reg + term_s;
                                state_reg <= S_T4;
                            end
                            S_T4:
                            begin
                                pv_acc_reg <= pv_acc_reg + 64'(term_mag);
                                state_reg  <= S_UPD;
                            end
                            S_DET:
                            begin
                                det_reg   <= mul_prod + pvk_pkg::EPS_DET;
                                state_reg <= S_N0;
                            end
                            S_N0:
                            begin
                                num_reg   <= mul_prod;
                                state_reg <= S_DIV0;
                            end
                            S_DIV0:
                            begin
                                k0_reg    <= div_quo;
                                state_reg <= S_N1;
                            end
                            S_N1:
                            begin
                                num_reg   <= mul_prod;
                                state_reg <= S_DIV1;
                            end
                            S_DIV1:
                            begin
                                k1_reg    <= div_quo;
                                state_reg <= S_TP;
                            end
                            S_TP:
                            begin
                                p_acc_reg <= 64'(pos_reg) + term_s;
                                state_reg <= S_TV;
                            end
                            S_TV:
                            begin
                                v_acc_reg <= 64'(vel_reg) + term_s;
                                state_reg <= S_PV;
                            end
                            S_PV:
                            begin
                                pv_acc_reg <= 64'(term_mag);
                                state_reg  <= S_VV;
                            end
                            S_VV:
                            begin
                                vv_acc_reg <= 64'(term_mag);
                                state_reg  <= S_UPD;
                            end
                            default:
                                state_reg <= S_IDLE;
                        endcase
                    end
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign position_est = pos_out_reg;
    assign velocity_est = vel_out_reg;
    assign position_var = pvar_out_reg;
    assign velocity_var = vvar_out_reg;

    // checks
    `PVK_ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall)
    `PVK_ASSERT_NOW(a_units_exclusive, 1'b1, !(mul_st.busy && div_st.busy))
    `PVK_ASSERT_NOW(a_load_from_out, $rose(out_valid_reg), $past(state_reg == S_OUT))

endmodule

// ===== rtl/pvk_mul.sv =====
// 64x64 unsigned multiply on one 32x32 multiplier, one partial product per cycle
module pvk_mul
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [63:0]          op_a,
    input  logic [63:0]          op_b,
    output pvk_pkg::wide_t       product,
    output pvk_pkg::unit_status_t status
);

    logic [63:0]    a_reg, b_reg;
    pvk_pkg::wide_t acc_reg;
    logic [1:0]     idx_reg;
    logic           busy_reg, done_reg;

    logic [31:0]    a_half, b_half;
    logic [63:0]    pp;
    pvk_pkg::wide_t pp_shifted;

    // pick halves: ll, lh, hl, hh
    always_comb
    begin
        a_half = idx_reg[1] ? a_reg[63:32] : a_reg[31:0];
        b_half = idx_reg[0] ? b_reg[63:32] : b_reg[31:0];
        pp     = 64'(a_half) * 64'(b_half);
        case (idx_reg)
            2'd0:    pp_shifted = 128'(pp);
            2'd1,
            2'd2:    pp_shifted = 128'(pp) << 32;
            default: pp_shifted = 128'(pp) << 64;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg    <= '0;
            b_reg    <= '0;
            acc_reg  <= '0;
            idx_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                a_reg    <= op_a;
                b_reg    <= op_b;
                acc_reg  <= '0;
                idx_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                acc_reg <= acc_reg + pp_shifted;
                idx_reg <= idx_reg + 2'd1;
                if (idx_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign product     = acc_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== rtl/pvk_div.sv =====
// Restoring divider: floor(num * 2^F / den), one quotient bit per cycle, num < den
module pvk_div
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  pvk_pkg::wide_t                  num,
    input  pvk_pkg::wide_t                  den,
    output logic [pvk_pkg::FRAC_BITS-1:0]   quo,
    output pvk_pkg::unit_status_t           status
);

    pvk_pkg::wide_t                   rem_reg, den_reg;
    logic [pvk_pkg::FRAC_BITS-1:0]    quo_reg;
    logic [pvk_pkg::DIV_CNT_W-1:0]    cnt_reg;
    logic                             busy_reg, done_reg;

    logic [128:0] rem_sh;
    logic [128:0] rem_sub;
    logic         fits;

    // trial subtract
    always_comb
    begin
        rem_sh  = {rem_reg, 1'b0};
        rem_sub = rem_sh - {1'b0, den_reg};
        fits    = (rem_sh >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            den_reg  <= '0;
            quo_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= num;
                den_reg  <= den;
                quo_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? rem_sub[127:0] : rem_sh[127:0];
                quo_reg <= {quo_reg[pvk_pkg::FRAC_BITS-2:0], fits};
                cnt_reg <= cnt_reg + pvk_pkg::DIV_CNT_W'(1);
                if (cnt_reg == pvk_pkg::DIV_CNT_W'(pvk_pkg::FRAC_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quo         = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule
